@@ rtl/hiqs_pkg.sv @@
// Shared types and constants for the Haar inverse quad shrink unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package hiqs_pkg;

   // Detail shrink modes as held in the mode register.
   typedef enum logic [1:0] {
      SHRINK_NONE    = 2'd0,
      SHRINK_HARD    = 2'd1,
      SHRINK_SOFT    = 2'd2,
      SHRINK_GARROTE = 2'd3
   } shrink_mode_type;

   // Register indexes on the configuration port.
   localparam int unsigned REG_MODE      = 0;
   localparam int unsigned REG_THRESHOLD = 1;

   // Threshold value after reset (50.0 in Q15.4).
   localparam int unsigned THR_RESET = 800;

endpackage

`default_nettype wire

@@ rtl/hiqs_shrink_lane.sv @@
// One detail lane: magnitude capture, pipelined restoring divider for the
// garrote quotient and the final shrink select. Depends on hiqs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hiqs_shrink_lane
   import hiqs_pkg::*;
#(
   parameter int COEF_BITS = 20
) (
   input  wire                             clock,
   input  wire  [COEF_BITS:0]              adv,
   input  wire  signed [COEF_BITS-1:0]     detail,
   input  shrink_mode_type                 mode,
   input  wire  [COEF_BITS-2:0]            thr,
   input  wire  [2*COEF_BITS-3:0]          thr_sq,
   output logic signed [COEF_BITS-1:0]     shrunk
);

   localparam int TW = COEF_BITS - 1;
   localparam int SW = 2 * TW;

   // Per-stage payload: stage 0 is the capture, 1..TW the divider steps.
   logic signed [COEF_BITS-1:0] x_ff     [0:TW];
   logic        [COEF_BITS-1:0] mag_ff   [0:TW];
   logic                        neg_ff   [0:TW];
   logic                        small_ff [0:TW];
   logic        [COEF_BITS-1:0] rem_ff   [1:TW];
   logic        [TW-1:0]        quo_ff   [1:TW];
   logic signed [COEF_BITS-1:0] shrunk_ff;

   logic        [COEF_BITS-1:0] mag_in;
   logic signed [COEF_BITS-1:0] res_in;
   logic        [COEF_BITS-1:0] res_mag;

   // Capture the detail with its sign and magnitude.
   assign mag_in = detail[COEF_BITS-1] ? COEF_BITS'(-detail) : COEF_BITS'(detail);

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         x_ff[0]     <= detail;
         mag_ff[0]   <= mag_in;
         neg_ff[0]   <= detail[COEF_BITS-1];
         small_ff[0] <= mag_in <= COEF_BITS'(thr);
      end
   end

   // One quotient bit per stage. The quotient is below the threshold, so the
   // partial remainder starts from the upper half of the squared threshold.
   for (genvar j = 1; j <= TW; j++) begin : g_div
      logic [COEF_BITS-1:0] rem_prev;
      logic [TW-1:0]        quo_prev;
      logic [COEF_BITS:0]   trial;
      logic                 fits;

      if (j == 1) begin : g_first
         assign rem_prev = COEF_BITS'(thr_sq[SW-1:TW]);
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[j-1];
         assign quo_prev = quo_ff[j-1];
      end

      assign trial = {rem_prev, thr_sq[TW-j]};
      assign fits  = trial >= {1'b0, mag_ff[j-1]};

      always_ff @(posedge clock) begin
         if (adv[j]) begin
            x_ff[j]     <= x_ff[j-1];
            mag_ff[j]   <= mag_ff[j-1];
            neg_ff[j]   <= neg_ff[j-1];
            small_ff[j] <= small_ff[j-1];
            rem_ff[j]   <= fits ? COEF_BITS'(trial - {1'b0, mag_ff[j-1]})
                                : trial[COEF_BITS-1:0];
            quo_ff[j]   <= {quo_prev[TW-2:0], fits};
         end
      end
   end

   // Final shrink by mode.
   always_comb begin
      res_mag = '0;
      res_in  = '0;
      case (mode)
         SHRINK_NONE: begin
            res_in = x_ff[TW];
         end
         SHRINK_HARD: begin
            res_in = small_ff[TW] ? '0 : x_ff[TW];
         end
         SHRINK_SOFT: begin
            res_mag = mag_ff[TW] - COEF_BITS'(thr);
            res_in  = small_ff[TW] ? '0 :
                      (neg_ff[TW] ? COEF_BITS'(-res_mag) : res_mag);
         end
         SHRINK_GARROTE: begin
            res_mag = mag_ff[TW] - COEF_BITS'(quo_ff[TW]);
            res_in  = small_ff[TW] ? '0 :
                      (neg_ff[TW] ? COEF_BITS'(-res_mag) : res_mag);
         end
         default: begin
            res_in = x_ff[TW];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv[TW+1]) begin
         shrunk_ff <= res_in;
      end
   end

   assign shrunk = shrunk_ff;

endmodule

`default_nettype wire

@@ rtl/hiqs_butterfly.sv @@
// Merging stage: signed butterfly of the approximation and three shrunk
// details into four pixels, held in the output register. Uses hiqs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hiqs_butterfly
   import hiqs_pkg::*;
#(
   parameter int COEF_BITS = 20
) (
   input  wire                             clock,
   input  wire                             load,
   input  wire  signed [COEF_BITS-1:0]     c,
   input  wire  signed [COEF_BITS-1:0]     h,
   input  wire  signed [COEF_BITS-1:0]     v,
   input  wire  signed [COEF_BITS-1:0]     d,
   output logic signed [COEF_BITS+1:0]     top_left,
   output logic signed [COEF_BITS+1:0]     top_right,
   output logic signed [COEF_BITS+1:0]     bottom_left,
   output logic signed [COEF_BITS+1:0]     bottom_right
);

   localparam int OW = COEF_BITS + 2;

   logic signed [OW-1:0] ce, he, ve, de;
   logic signed [OW-1:0] tl_ff, tr_ff, bl_ff, br_ff;

   assign ce = OW'(c);
   assign he = OW'(h);
   assign ve = OW'(v);
   assign de = OW'(d);

   // The raw sum is the pixel with one more fraction bit, so no rounding.
   always_ff @(posedge clock) begin
      if (load) begin
         tl_ff <= ce + he + ve + de;
         tr_ff <= ce - he + ve - de;
         bl_ff <= ce + he - ve - de;
         br_ff <= ce - he - ve + de;
      end
   end

   assign top_left     = tl_ff;
   assign top_right    = tr_ff;
   assign bottom_left  = bl_ff;
   assign bottom_right = br_ff;

endmodule

`default_nettype wire

@@ rtl/haar_inverse_quad_shrink_unit.sv @@
// Top level of the Haar inverse quad shrink unit: handshake pipeline, CSRs,
// three shrink lanes and the butterfly. Depends on hiqs_pkg, hiqs_shrink_lane,
// hiqs_butterfly.
//
//   Channel  Direction  Carries
//   req_*    in         one coefficient quad per beat
//   rsp_*    out        four reconstructed pixels per beat
//   csr_*    in/out     APB registers: mode at 0x0, threshold at 0x4
//
// One quad per cycle sustained while rsp_tready holds; a result leaves through
// COEF_BITS+2 register stages, most of them in the restoring divider that
// yields one garrote quotient bit per stage.
// Reset is synchronous; it clears the stage valids and mode and sets the threshold to THR_RESET.
// Each stage holds while the next one is full and stalled, so bubbles are
// squeezed out and input keeps flowing into empty stages while a result waits.
`timescale 1ns / 1ps
`default_nettype none

module haar_inverse_quad_shrink_unit
   import hiqs_pkg::*;
#(
   parameter int COEF_BITS = 20
) (
   input  wire                                        clock,
   input  wire                                        reset,
   // approx_coef, horiz_detail, vert_detail, diag_detail from bit 0 up
   input  wire  [((4*COEF_BITS+7)/8)*8-1:0]           req_tdata,
   input  wire                                        req_tvalid,
   output logic                                       req_tready,
   // pix_top_left, pix_top_right, pix_bottom_left, pix_bottom_right from bit 0
   output logic [((4*(COEF_BITS+2)+7)/8)*8-1:0]       rsp_tdata,
   output logic                                       rsp_tvalid,
   input  wire                                        rsp_tready,
   input  wire                                        csr_psel,
   input  wire                                        csr_penable,
   input  wire                                        csr_pwrite,
   input  wire  [2:0]                                 csr_paddr,
   input  wire  [31:0]                                csr_pwdata,
   output logic [31:0]                                csr_prdata,
   output logic                                       csr_pready
);

   localparam int TW    = COEF_BITS - 1;
   localparam int SW    = 2 * TW;
   localparam int OW    = COEF_BITS + 2;
   localparam int NST   = TW + 3;
   localparam int OUT_W = ((4*OW+7)/8)*8;

   // Configuration registers.
   shrink_mode_type mode_ff, mode_in;
   logic [TW-1:0]   thr_ff, thr_in;
   logic [SW-1:0]   tsq_ff, tsq_in;
   logic            csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      mode_in = mode_ff;
      thr_in  = thr_ff;
      if (csr_wr) begin
         case (32'(csr_paddr[2]))
            REG_MODE:      mode_in = shrink_mode_type'(csr_pwdata[1:0]);
            REG_THRESHOLD: thr_in  = csr_pwdata[TW-1:0];
            default:       mode_in = mode_ff;
         endcase
      end
   end

   always_comb begin
      case (32'(csr_paddr[2]))
         REG_MODE:      csr_prdata = 32'(mode_ff);
         REG_THRESHOLD: csr_prdata = 32'(thr_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // Squared threshold, shared by the three lane dividers.
   assign tsq_in = thr_ff * thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= SHRINK_NONE;
         thr_ff  <= TW'(THR_RESET);
      end else begin
         mode_ff <= mode_in;
         thr_ff  <= thr_in;
      end
      tsq_ff <= tsq_in;
   end

   // Stage valids; a stage loads when it is empty or its content moves on.
   logic [NST-1:0] vld_ff, vld_in;
   logic [NST:0]   rdy;

   always_comb begin
      rdy[NST] = rsp_tready;
      for (int k = NST - 1; k >= 0; k--) begin
         rdy[k] = ~vld_ff[k] | rdy[k+1];
      end
      vld_in[0] = rdy[0] ? req_tvalid : vld_ff[0];
      for (int k = 1; k < NST; k++) begin
         if (rdy[k]) begin
            vld_in[k] = vld_ff[k-1];
         end else begin
            vld_in[k] = vld_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_tready = rdy[0];
   assign rsp_tvalid = vld_ff[NST-1];

   // Approximation coefficient travels beside the lanes.
   logic signed [COEF_BITS-1:0] approx_ff [0:NST-2];

   for (genvar k = 0; k < NST - 1; k++) begin : g_approx
      always_ff @(posedge clock) begin
         if (rdy[k]) begin
            approx_ff[k] <= (k == 0) ? req_tdata[COEF_BITS-1:0] : approx_ff[k == 0 ? 0 : k-1];
         end
      end
   end

   // Three detail lanes.
   logic signed [COEF_BITS-1:0] shrunk [0:2];

   for (genvar l = 0; l < 3; l++) begin : g_lane
      hiqs_shrink_lane #(
         .COEF_BITS (COEF_BITS)
      ) u_lane (
         .clock  (clock),
         .adv    (rdy[TW+1:0]),
         .detail (req_tdata[(l+2)*COEF_BITS-1:(l+1)*COEF_BITS]),
         .mode   (mode_ff),
         .thr    (thr_ff),
         .thr_sq (tsq_ff),
         .shrunk (shrunk[l])
      );
   end

   // Butterfly into the output register.
   logic signed [OW-1:0] pix_tl, pix_tr, pix_bl, pix_br;

   hiqs_butterfly #(
      .COEF_BITS (COEF_BITS)
   ) u_bfly (
      .clock        (clock),
      .load         (rdy[NST-1]),
      .c            (approx_ff[NST-2]),
      .h            (shrunk[0]),
      .v            (shrunk[1]),
      .d            (shrunk[2]),
      .top_left     (pix_tl),
      .top_right    (pix_tr),
      .bottom_left  (pix_bl),
      .bottom_right (pix_br)
   );

   assign rsp_tdata = OUT_W'({pix_br, pix_bl, pix_tr, pix_tl});

   // A mode write shows up in the register in the next cycle.
   a_mode_write: assert property (@(posedge clock) disable iff (reset)
      (csr_wr && csr_paddr[2] == 1'b0) |=> mode_ff == $past(csr_pwdata[1:0]))
      else $error("mode register missed a write");

   // The shared square follows the threshold register.
   a_thr_square: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> tsq_ff == SW'($past(thr_ff)) * SW'($past(thr_ff)))
      else $error("squared threshold out of step");

   // A full stage in front of a stalled output stage keeps its beat.
   a_hold_beat: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[NST-1] && !rsp_tready && vld_ff[NST-2]) |=> vld_ff[NST-2])
      else $error("beat dropped behind stalled output");

endmodule

`default_nettype wire
